FILE: design/gwsc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the grid word search counter
package gwsc_pkg;

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int HERE_W     = 4;
    localparam int TOTAL_W    = 24;
    localparam int WORD_W     = 32;
    localparam int WORD_BYTES = 4;
    localparam int WLEN_W     = 3;
    localparam int GWID_W     = 9;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_CHARS  = 2'd0,
        CFG_WORD_LENGTH = 2'd1,
        CFG_GRID_WIDTH  = 2'd2
    } gwsc_cfg_idx_t;

    // register reset values
    localparam logic [WORD_W-1:0] WORD_CHARS_RST  = 32'd1396788568;
    localparam logic [WLEN_W-1:0] WORD_LENGTH_RST = 3'd4;
    localparam logic [GWID_W-1:0] GRID_WIDTH_RST  = 9'd140;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    // the four lines that end at a cell
    localparam int NUM_LINES = 4;
    localparam int LINE_LEFT = 0;
    localparam int LINE_UP   = 1;
    localparam int LINE_UL   = 2;
    localparam int LINE_UR   = 3;

    // per-cell compare result, one bit per line and direction
    typedef struct packed {
        logic [NUM_LINES-1:0] fwd;
        logic [NUM_LINES-1:0] rev;
    } gwsc_hits_t;

endpackage

FILE: design/gwsc_cell.sv
`timescale 1ns / 1ps
// one tap of the match chain: holds a current-row char and compares its line chars
module gwsc_cell (
    input  logic                     aclk,
    input  logic                     shift_en,
    input  logic [gwsc_pkg::CHAR_W-1:0] char_in,
    output logic [gwsc_pkg::CHAR_W-1:0] char_out,
    input  logic [gwsc_pkg::CHAR_W-1:0] up_char,
    input  logic [gwsc_pkg::CHAR_W-1:0] ul_char,
    input  logic [gwsc_pkg::CHAR_W-1:0] ur_char,
    input  logic [gwsc_pkg::CHAR_W-1:0] fwd_byte,
    input  logic [gwsc_pkg::CHAR_W-1:0] rev_byte,
    input  logic                     active,
    output gwsc_pkg::gwsc_hits_t     hits
);
    import gwsc_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] line_char [NUM_LINES];

    // char of the current row, handed to the next tap on every accepted word
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            char_reg <= char_in;
        end
    end

    assign char_out = char_reg;

    always_comb begin
        line_char[LINE_LEFT] = char_reg;
        line_char[LINE_UP]   = up_char;
        line_char[LINE_UL]   = ul_char;
        line_char[LINE_UR]   = ur_char;
        for (int l = 0; l < NUM_LINES; l++) begin
            // taps beyond the word length never block a match
            hits.fwd[l] = !active || (line_char[l] == fwd_byte);
            hits.rev[l] = !active || (line_char[l] == rev_byte);
        end
    end

endmodule

FILE: design/gwsc_line_store.sv
`timescale 1ns / 1ps
// circular row store, one bank per row slot, two copies for three reads per bank
module gwsc_line_store #(
    parameter int MAX_WORD    = 4,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [((MAX_WORD > 1) ? $clog2(MAX_WORD) : 1)-1:0] wr_slot,
    input  logic [$clog2(MAX_COLUMNS)-1:0] col,
    input  logic [gwsc_pkg::CHAR_W-1:0]    wr_char,
    output logic [gwsc_pkg::CHAR_W-1:0]    back_up [MAX_WORD],
    output logic [gwsc_pkg::CHAR_W-1:0]    back_ul [MAX_WORD],
    output logic [gwsc_pkg::CHAR_W-1:0]    back_ur [MAX_WORD]
);
    import gwsc_pkg::*;

    localparam int SLOT_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int AX_W   = ADDR_W + SLOT_W + 1;

    logic [CHAR_W-1:0] rd_up_reg [MAX_WORD];
    logic [CHAR_W-1:0] rd_ul_reg [MAX_WORD];
    logic [CHAR_W-1:0] rd_ur_reg [MAX_WORD];
    logic [SLOT_W-1:0] rd_back_reg [MAX_WORD];

    for (genvar s = 0; s < MAX_WORD; s++) begin : g_bank
        logic [CHAR_W-1:0] mem_a [MAX_COLUMNS];
        logic [CHAR_W-1:0] mem_b [MAX_COLUMNS];
        logic [SLOT_W-1:0] back_k;
        logic [AX_W-1:0]   ur_x;
        logic [ADDR_W-1:0] ul_addr;
        logic [ADDR_W-1:0] ur_addr;

        // how many rows back this bank sits from the row being written
        assign back_k = (wr_slot >= SLOT_W'(s)) ? wr_slot - SLOT_W'(s)
                                                : SLOT_W'(wr_slot + SLOT_W'(MAX_WORD - s));
        assign ur_x   = AX_W'(col) + AX_W'(back_k);
        assign ul_addr = (AX_W'(col) >= AX_W'(back_k)) ? ADDR_W'(AX_W'(col) - AX_W'(back_k))
                                                       : col;
        assign ur_addr = (ur_x < AX_W'(MAX_COLUMNS)) ? ADDR_W'(ur_x) : col;

        always_ff @(posedge aclk) begin
            if (en && (wr_slot == SLOT_W'(s))) begin
                mem_a[col] <= wr_char;
                mem_b[col] <= wr_char;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rd_up_reg[s]   <= mem_a[col];
                rd_ul_reg[s]   <= mem_a[ul_addr];
                rd_ur_reg[s]   <= mem_b[ur_addr];
                rd_back_reg[s] <= back_k;
            end
        end
    end

    // route bank data to row distance
    always_comb begin
        for (int k = 0; k < MAX_WORD; k++) begin
            back_up[k] = '0;
            back_ul[k] = '0;
            back_ur[k] = '0;
            for (int s = 0; s < MAX_WORD; s++) begin
                if (rd_back_reg[s] == SLOT_W'(k)) begin
                    back_up[k] = rd_up_reg[s];
                    back_ul[k] = rd_ul_reg[s];
                    back_ur[k] = rd_ur_reg[s];
                end
            end
        end
    end

endmodule

FILE: design/grid_word_search_counter.sv
`timescale 1ns / 1ps
// top level of the grid word search counter
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_cell_char s_last_cell        | in
//  result  | m_valid m_ready m_matches_here m_total_matches | out
//          | m_grid_done                                    |
//  config  | cfg_wr_en cfg_index cfg_wdata                  | in
//
// one word per cycle while m_ready keeps the result register free; a result passes stage a, then the result register
// the row store banks have one write and at most two registered reads per copy,
// which fixes the two-stage path: store read, then compare and count
// reset clears positions, running total, config and valid flags;
// the row store itself is not cleared
// with m_ready low the result register holds and one more word still enters
module grid_word_search_counter #(
    parameter int MAX_WORD    = 4,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gwsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gwsc_pkg::WORD_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gwsc_pkg::CHAR_W-1:0]        s_cell_char,
    input  logic                               s_last_cell,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gwsc_pkg::HERE_W-1:0]        m_matches_here,
    output logic [gwsc_pkg::TOTAL_W-1:0]       m_total_matches,
    output logic                               m_grid_done
);
    import gwsc_pkg::*;

    localparam int SLOT_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LEN_W  = $clog2(MAX_WORD + 1);
    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int WID_W  = $clog2(MAX_COLUMNS + 1);
    localparam int GW_X   = (WID_W > GWID_W) ? WID_W : GWID_W;
    localparam int CHK_W  = WID_W + 2;

    // configuration registers
    logic [WORD_W-1:0] word_chars_reg;
    logic [WLEN_W-1:0] word_length_reg;
    logic [GWID_W-1:0] grid_width_reg;

    // grid position
    logic [ADDR_W-1:0] col_reg,  col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] rows_reg, rows_next;   // rows seen, saturates at MAX_WORD-1

    // stage a: store read data and cell chars are valid
    logic              a_valid_reg, a_valid_next;
    logic [ADDR_W-1:0] a_col_reg;
    logic [SLOT_W-1:0] a_rows_reg;
    logic              a_last_reg;

    // result register and running total
    logic               m_valid_reg, m_valid_next;
    logic [HERE_W-1:0]  m_here_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    logic               m_done_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic accept, a_move, b_free;

    // effective config
    logic [LEN_W-1:0] len_eff, len_m1;
    logic [GW_X-1:0]  gw_x;
    logic [WID_W-1:0] width_eff;

    // entry stage position logic
    logic              start_wrap, end_wrap;
    logic [ADDR_W-1:0] c_start;
    logic [SLOT_W-1:0] slot_start, slot_inc_start;
    logic [SLOT_W-1:0] rows_start, rows_inc_start;
    logic [WID_W-1:0]  c_plus;

    // chain and store wiring
    logic [CHAR_W-1:0] left_char [MAX_WORD];
    logic [CHAR_W-1:0] st_up [MAX_WORD];
    logic [CHAR_W-1:0] st_ul [MAX_WORD];
    logic [CHAR_W-1:0] st_ur [MAX_WORD];
    logic [CHAR_W-1:0] fwd_byte [MAX_WORD];
    logic [CHAR_W-1:0] rev_byte [MAX_WORD];
    logic [LEN_W-1:0]  fwd_pos [MAX_WORD];
    logic              tap_active [MAX_WORD];
    gwsc_hits_t        hits [MAX_WORD];

    // match evaluation
    logic [NUM_LINES-1:0] line_ok, line_fwd, line_rev;
    logic [HERE_W-1:0]    here;
    logic [TOTAL_W:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_chars_reg  <= WORD_CHARS_RST;
            word_length_reg <= WORD_LENGTH_RST;
            grid_width_reg  <= GRID_WIDTH_RST;
        end else if (cfg_wr_en) begin
            unique case (gwsc_cfg_idx_t'(cfg_index))
                CFG_WORD_CHARS:  word_chars_reg  <= cfg_wdata;
                CFG_WORD_LENGTH: word_length_reg <= cfg_wdata[WLEN_W-1:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GWID_W-1:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    // word length clamped to 1..MAX_WORD, width clamped to 1..MAX_COLUMNS
    always_comb begin
        if (word_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (4'(word_length_reg) > 4'(MAX_WORD)) begin
            len_eff = LEN_W'(MAX_WORD);
        end else begin
            len_eff = LEN_W'(word_length_reg);
        end
        len_m1 = len_eff - LEN_W'(1);

        gw_x = GW_X'(grid_width_reg);
        if (gw_x == '0) begin
            width_eff = WID_W'(1);
        end else if (gw_x > GW_X'(MAX_COLUMNS)) begin
            width_eff = WID_W'(MAX_COLUMNS);
        end else begin
            width_eff = WID_W'(gw_x);
        end
    end

    // ---------------------------------------------------------------
    // handshake: result register, stage a, entry
    // ---------------------------------------------------------------
    assign b_free  = !m_valid_reg || m_ready;
    assign a_move  = a_valid_reg && b_free;
    assign s_ready = !a_valid_reg || b_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (a_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // grid position; a row also ends early if the width was lowered
    // ---------------------------------------------------------------
    always_comb begin
        start_wrap = WID_W'(col_reg) >= width_eff;
        c_start    = start_wrap ? '0 : col_reg;

        slot_inc_start = (slot_reg == SLOT_W'(MAX_WORD - 1)) ? '0 : slot_reg + SLOT_W'(1);
        rows_inc_start = (rows_reg == SLOT_W'(MAX_WORD - 1)) ? rows_reg : rows_reg + SLOT_W'(1);
        slot_start = start_wrap ? slot_inc_start : slot_reg;
        rows_start = start_wrap ? rows_inc_start : rows_reg;

        c_plus   = WID_W'(c_start) + WID_W'(1);
        end_wrap = c_plus >= width_eff;

        if (s_last_cell) begin
            col_next  = '0;
            slot_next = '0;
            rows_next = '0;
        end else if (end_wrap) begin
            col_next  = '0;
            slot_next = (slot_start == SLOT_W'(MAX_WORD - 1)) ? '0 : slot_start + SLOT_W'(1);
            rows_next = (rows_start == SLOT_W'(MAX_WORD - 1)) ? rows_start
                                                               : rows_start + SLOT_W'(1);
        end else begin
            col_next  = ADDR_W'(c_plus);
            slot_next = slot_start;
            rows_next = rows_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            slot_reg    <= '0;
            rows_reg    <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                col_reg  <= col_next;
                slot_reg <= slot_next;
                rows_reg <= rows_next;
            end
            if (a_move) begin
                total_reg <= total_next;
            end
        end
    end

    // stage a payload, taken with the word
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_col_reg  <= c_start;
            a_rows_reg <= rows_start;
            a_last_reg <= s_last_cell;
        end
    end

    // ---------------------------------------------------------------
    // row store: write this char, read the rows above
    // ---------------------------------------------------------------
    gwsc_line_store #(
        .MAX_WORD    (MAX_WORD),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_line_store (
        .aclk    (aclk),
        .en      (accept),
        .wr_slot (slot_start),
        .col     (c_start),
        .wr_char (s_cell_char),
        .back_up (st_up),
        .back_ul (st_ul),
        .back_ur (st_ur)
    );

    // ---------------------------------------------------------------
    // word bytes per tap: reverse uses byte k, forward uses byte len-1-k
    // bytes past the fourth compare as zero
    // ---------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < MAX_WORD; k++) begin
            tap_active[k] = LEN_W'(k) < len_eff;
            fwd_pos[k]    = len_m1 - LEN_W'(k);
            fwd_byte[k]   = '0;
            rev_byte[k]   = '0;
            for (int b = 0; b < WORD_BYTES; b++) begin
                if (4'(fwd_pos[k]) == 4'(b)) begin
                    fwd_byte[k] = word_chars_reg[CHAR_W*b +: CHAR_W];
                end
                if (k == b) begin
                    rev_byte[k] = word_chars_reg[CHAR_W*b +: CHAR_W];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // chain of taps; tap k sees the chars k steps back on each line
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAX_WORD; k++) begin : g_tap
        if (k == 0) begin : g_head
            // the cell itself closes every line
            gwsc_cell u_cell (
                .aclk     (aclk),
                .shift_en (accept),
                .char_in  (s_cell_char),
                .char_out (left_char[k]),
                .up_char  (left_char[k]),
                .ul_char  (left_char[k]),
                .ur_char  (left_char[k]),
                .fwd_byte (fwd_byte[k]),
                .rev_byte (rev_byte[k]),
                .active   (tap_active[k]),
                .hits     (hits[k])
            );
        end else begin : g_body
            gwsc_cell u_cell (
                .aclk     (aclk),
                .shift_en (accept),
                .char_in  (left_char[k-1]),
                .char_out (left_char[k]),
                .up_char  (st_up[k]),
                .ul_char  (st_ul[k]),
                .ur_char  (st_ur[k]),
                .fwd_byte (fwd_byte[k]),
                .rev_byte (rev_byte[k]),
                .active   (tap_active[k]),
                .hits     (hits[k])
            );
        end
    end

    // ---------------------------------------------------------------
    // edge checks and match count for the word in stage a
    // ---------------------------------------------------------------
    always_comb begin
        logic col_ok, row_ok, right_ok;
        col_ok   = CHK_W'(a_col_reg) >= CHK_W'(len_m1);
        row_ok   = LEN_W'(a_rows_reg) >= len_m1;
        right_ok = (CHK_W'(a_col_reg) + CHK_W'(len_m1)) < CHK_W'(width_eff);

        line_ok[LINE_LEFT] = col_ok;
        line_ok[LINE_UP]   = row_ok;
        line_ok[LINE_UL]   = row_ok && col_ok;
        line_ok[LINE_UR]   = row_ok && right_ok;

        line_fwd = line_ok;
        line_rev = line_ok;
        for (int k = 0; k < MAX_WORD; k++) begin
            line_fwd = line_fwd & hits[k].fwd;
            line_rev = line_rev & hits[k].rev;
        end

        // a palindrome counts in both directions
        here = '0;
        for (int l = 0; l < NUM_LINES; l++) begin
            here = here + HERE_W'(line_fwd[l]) + HERE_W'(line_rev[l]);
        end

        total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(here);
        total_sat  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        // total clears after the closing cell
        total_next = a_last_reg ? '0 : total_sat;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (a_move) begin
            m_here_reg  <= here;
            m_total_reg <= total_sat;
            m_done_reg  <= a_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_matches_here  = m_here_reg;
    assign m_total_matches = m_total_reg;
    assign m_grid_done     = m_done_reg;

endmodule

FILE: design/gwsc_checker.sv
`timescale 1ns / 1ps
// port-level checker for the grid word search counter, bound to the top level
module gwsc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [gwsc_pkg::HERE_W-1:0]  m_matches_here,
    input logic [gwsc_pkg::TOTAL_W-1:0] m_total_matches,
    input logic                         m_grid_done
);
    import gwsc_pkg::*;

    logic               first_reg, first_next;
    logic [TOTAL_W-1:0] prev_total_reg;
    logic [1:0]         pending_reg, pending_next;
    logic               s_fire, m_fire;
    logic [TOTAL_W:0]   exp_sum;
    logic [TOTAL_W-1:0] exp_total;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        first_next   = m_fire ? m_grid_done : first_reg;
        pending_next = pending_reg + 2'(s_fire) - 2'(m_fire);
        exp_sum      = {1'b0, prev_total_reg} + (TOTAL_W + 1)'(m_matches_here);
        exp_total    = exp_sum[TOTAL_W] ? TOTAL_MAX : exp_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg   <= 1'b1;
            pending_reg <= '0;
        end else begin
            first_reg   <= first_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_fire) begin
            prev_total_reg <= m_total_matches;
        end
    end

    // at most eight occurrences end at one cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_matches_here <= 4'd8)
        else $error("matches_here above eight");

    // first result of a grid starts the total from zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && first_reg) |-> m_total_matches == TOTAL_W'(m_matches_here))
        else $error("total did not restart at grid start");

    // later results add to the previous total, saturating
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !first_reg) |-> m_total_matches == exp_total)
        else $error("running total does not follow the counts");

    // every result belongs to a word taken in, at most two in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg == 2'd1 || pending_reg == 2'd2))
        else $error("result without a pending word");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_total_matches)
                                   && $stable(m_matches_here) && $stable(m_grid_done)))
        else $error("stalled result changed");

endmodule

bind grid_word_search_counter gwsc_checker u_gwsc_checker (.*);

FILE: tb/word_hit_checker.sv
`timescale 1ns / 1ps
// checker for the grid word search counter: predicts each cell's result and compares
module word_hit_checker #(
    parameter int MAX_WORD    = 4,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gwsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gwsc_pkg::WORD_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [gwsc_pkg::CHAR_W-1:0]        s_cell_char,
    input  logic                               s_last_cell,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [gwsc_pkg::HERE_W-1:0]        m_matches_here,
    input  logic [gwsc_pkg::TOTAL_W-1:0]       m_total_matches,
    input  logic                               m_grid_done,
    output int                                 mismatch_count,
    output int                                 outstanding
);
    import gwsc_pkg::*;

    localparam int ROW_LIMIT = 65535;

    typedef struct packed {
        logic [HERE_W-1:0]  here;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } cell_score_t;

    cell_score_t expected_scores[$];
    int          errors_seen = 0;

    logic [CHAR_W-1:0] grid_rows [0:MAX_WORD*MAX_COLUMNS-1];
    int unsigned       col_pos, row_pos, slot_pos;
    logic [TOTAL_W-1:0] running_total;
    logic [WORD_W-1:0] word_reg;
    logic [WLEN_W-1:0] len_reg;
    logic [GWID_W-1:0] width_reg;

    assign mismatch_count = errors_seen;

    function automatic int unsigned active_len();
        if (len_reg == 0) return 1;
        if (len_reg > MAX_WORD) return MAX_WORD;
        return len_reg;
    endfunction

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return width_reg;
    endfunction

    function automatic logic [CHAR_W-1:0] word_char(int unsigned k);
        if (k >= WORD_BYTES) return '0;
        return word_reg[8*k +: 8];
    endfunction

    // character 'back' rows above the current one, circular over the stored rows
    function automatic logic [CHAR_W-1:0] row_char(int unsigned back, int unsigned col);
        int unsigned slot;
        slot = (slot_pos + MAX_WORD - (back % MAX_WORD)) % MAX_WORD;
        return grid_rows[slot*MAX_COLUMNS + (col % MAX_COLUMNS)];
    endfunction

    // forward plus reversed hits on one line ending at the current cell
    function automatic int unsigned line_matches(int unsigned len, int unsigned wid,
                                                 bit climbs, int dc);
        int unsigned c;
        int unsigned cc;
        bit          fwd;
        bit          rev;
        logic [CHAR_W-1:0] ch;
        c   = col_pos;
        fwd = 1'b1;
        rev = 1'b1;
        if (climbs && row_pos < len - 1) return 0;
        if (dc < 0 && c < len - 1) return 0;
        if (dc > 0 && c + len - 1 >= wid) return 0;
        for (int unsigned k = 0; k < len; k++) begin
            cc = (dc < 0) ? c - k : ((dc > 0) ? c + k : c);
            ch = row_char(climbs ? k : 0, cc);
            if (ch != word_char(len - 1 - k)) fwd = 1'b0;
            if (ch != word_char(k)) rev = 1'b0;
        end
        return int'(fwd) + int'(rev);
    endfunction

    function automatic void advance_row();
        col_pos = 0;
        if (row_pos < ROW_LIMIT) row_pos++;
        slot_pos = (slot_pos + 1) % MAX_WORD;
    endfunction

    function automatic void clear_positions();
        col_pos       = 0;
        row_pos       = 0;
        slot_pos      = 0;
        running_total = '0;
    endfunction

    function automatic cell_score_t score_cell(logic [CHAR_W-1:0] ch, logic last);
        int unsigned wid;
        int unsigned len;
        int unsigned here;
        int unsigned sum;
        cell_score_t r;
        wid = active_width();
        len = active_len();
        if (col_pos >= wid) advance_row();
        grid_rows[slot_pos*MAX_COLUMNS + col_pos] = ch;
        here = line_matches(len, wid, 1'b0, -1) + line_matches(len, wid, 1'b1, 0)
             + line_matches(len, wid, 1'b1, -1) + line_matches(len, wid, 1'b1, 1);
        sum = running_total + here;
        running_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        r.here  = here[HERE_W-1:0];
        r.total = running_total;
        r.done  = last;
        if (last) begin
            clear_positions();
        end else begin
            col_pos++;
            if (col_pos >= wid) advance_row();
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cell_score_t want;
        if (!aresetn) begin
            expected_scores.delete();
            clear_positions();
            for (int i = 0; i < MAX_WORD*MAX_COLUMNS; i++) grid_rows[i] = '0;
            word_reg  = WORD_CHARS_RST;
            len_reg   = WORD_LENGTH_RST;
            width_reg = GRID_WIDTH_RST;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_scores.size() == 0) begin
                    $error("unexpected result: matches_here %0d total_matches %0d grid_done %0d",
                           m_matches_here, m_total_matches, m_grid_done);
                    errors_seen++;
                end else begin
                    want = expected_scores.pop_front();
                    if (m_matches_here !== want.here) begin
                        $error("matches_here expected %0d actual %0d", want.here, m_matches_here);
                        errors_seen++;
                    end
                    if (m_total_matches !== want.total) begin
                        $error("total_matches expected %0d actual %0d",
                               want.total, m_total_matches);
                        errors_seen++;
                    end
                    if (m_grid_done !== want.done) begin
                        $error("grid_done expected %0d actual %0d", want.done, m_grid_done);
                        errors_seen++;
                    end
                end
            end
            if (s_valid && s_ready) expected_scores.push_back(score_cell(s_cell_char, s_last_cell));
            if (cfg_wr_en) begin
                if (cfg_index == CFG_WORD_CHARS) word_reg = cfg_wdata;
                else if (cfg_index == CFG_WORD_LENGTH) len_reg = cfg_wdata[WLEN_W-1:0];
                else if (cfg_index == CFG_GRID_WIDTH) width_reg = cfg_wdata[GWID_W-1:0];
            end
            outstanding <= expected_scores.size();
        end
    end

endmodule

FILE: tb/grid_word_search_counter_tb.sv
`timescale 1ns / 1ps
// testbench top for the grid word search counter: stimulus, flow control and verdict
module grid_word_search_counter_tb;
    import gwsc_pkg::*;

    localparam int MAX_WORD     = 4;
    localparam int MAX_COLUMNS  = 256;
    localparam int LATENCY      = 2;      // a result passes stage a and the result register after its word
    localparam int RANDOM_CELLS = 1420;
    localparam int CALM_FROM    = 1300;   // no idling on either side past this many words

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WORD_W-1:0]      cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_cell_char;
    logic                   s_last_cell;
    logic                   m_valid;
    logic                   m_ready;
    logic [HERE_W-1:0]      m_matches_here;
    logic [TOTAL_W-1:0]     m_total_matches;
    logic                   m_grid_done;

    int mismatch_count;
    int outstanding;

    // current register contents as written, kept so that partial updates can re-send them
    logic [WORD_W-1:0] cur_word;
    logic [WLEN_W-1:0] cur_len;
    logic [GWID_W-1:0] cur_width;

    int    cells_sent = 0;
    bit    idle_on    = 1'b1;
    bit    calm       = 1'b0;
    bit    noisy      = 1'b0;
    int    stall_left = 0;
    string letters    = "XMAS";

    grid_word_search_counter #(
        .MAX_WORD    (MAX_WORD),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_char     (s_cell_char),
        .s_last_cell     (s_last_cell),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_matches_here  (m_matches_here),
        .m_total_matches (m_total_matches),
        .m_grid_done     (m_grid_done)
    );

    word_hit_checker #(
        .MAX_WORD    (MAX_WORD),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_char     (s_cell_char),
        .s_last_cell     (s_last_cell),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_matches_here  (m_matches_here),
        .m_total_matches (m_total_matches),
        .m_grid_done     (m_grid_done),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side back-pressure: m_ready drops in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int unsigned eff_width(logic [GWID_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_COLUMNS) return MAX_COLUMNS;
        return w;
    endfunction

    // write all three registers back to back; only called with the block drained
    task automatic program_regs(input logic [WORD_W-1:0] word, input logic [WLEN_W-1:0] len,
                                input logic [GWID_W-1:0] width);
        cur_word  = word;
        cur_len   = len;
        cur_width = width;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WORD_CHARS;
        cfg_wdata <= word;
        @(posedge aclk);
        cfg_index <= CFG_WORD_LENGTH;
        cfg_wdata <= WORD_W'(len);
        @(posedge aclk);
        cfg_index <= CFG_GRID_WIDTH;
        cfg_wdata <= WORD_W'(width);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, let every expected result come out, then allow the pipe to empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // one word on the input channel; valid stays high afterwards unless a gap follows
    task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic last);
        if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cell_char <= ch;
        s_last_cell <= last;
        do @(posedge aclk); while (!s_ready);
        cells_sent++;
        calm = (cells_sent >= CALM_FROM);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_cell(t[i], i == t.len() - 1);
    endtask

    // mostly letters of the current word so that hits happen, with some raw bytes
    function automatic logic [CHAR_W-1:0] pick_char();
        if (noisy || $urandom_range(0, 99) >= 80) return CHAR_W'($urandom_range(0, 255));
        return cur_word[8*$urandom_range(0, WORD_BYTES-1) +: 8];
    endfunction

    task automatic pick_config();
        logic [7:0]        a;
        logic [7:0]        b;
        logic [WORD_W-1:0] word;
        logic [WLEN_W-1:0] len;
        logic [GWID_W-1:0] width;
        int                r;
        a = letters[$urandom_range(0, 3)];
        b = letters[$urandom_range(0, 3)];
        case ($urandom_range(0, 3))
            0: word = $urandom();
            1: word = {letters[$urandom_range(0, 3)], letters[$urandom_range(0, 3)], b, a};
            2: word = {a, b, b, a};                       // palindrome when all four letters are used, counts twice
            default: word = WORD_CHARS_RST;
        endcase
        if ($urandom_range(0, 4) == 0) len = WLEN_W'($urandom_range(0, 7));
        else len = WLEN_W'($urandom_range(1, MAX_WORD));
        r = $urandom_range(0, 59);
        if (r == 0) width = '0;
        else if (r == 1) width = GWID_W'($urandom_range(MAX_COLUMNS + 1, 511));
        else if (r == 2) width = GWID_W'(MAX_COLUMNS);
        else if (r == 3) width = GWID_W'($urandom_range(13, 64));
        else width = GWID_W'($urandom_range(1, 12));
        program_regs(word, len, width);
    endtask

    // one grid with random content; may end mid-row and may narrow the width part way
    task automatic run_grid();
        int unsigned w;
        int          n;
        int          shrink_at;
        w = eff_width(cur_width);
        if (w >= 64) n = $urandom_range(w / 4, w + 8);
        else n = w * $urandom_range(1, 8);
        if ($urandom_range(0, 3) == 0) n = n - $urandom_range(0, w - 1);
        if (n < 1) n = 1;
        shrink_at = ($urandom_range(0, 7) == 0 && n > 2) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == shrink_at) begin
                wait_drained();
                w = eff_width(cur_width);
                if (w > 1) program_regs(cur_word, cur_len, GWID_W'($urandom_range(1, w - 1)));
            end
            send_cell(pick_char(), i == n - 1);
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_WORD_CHARS;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_cell_char <= '0;
        s_last_cell <= 1'b0;
        cur_word    = WORD_CHARS_RST;
        cur_len     = WORD_LENGTH_RST;
        cur_width   = GRID_WIDTH_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 4x4 grid with the default word: horizontal hits, forward and reversed
        program_regs(WORD_CHARS_RST, 3'd4, 9'd4);
        send_text("XMASSAMXMAMMSAAS");
        wait_drained();

        // zero length acts as one letter, zero width as one column: eight hits per cell
        program_regs(32'h0000_0041, 3'd0, 9'd0);
        send_text("AA");
        wait_drained();

        // length above the maximum and width above the store both saturate
        program_regs(32'hFFFF_FFFF, 3'd7, 9'd300);
        for (int i = 0; i < 4; i++) send_cell(8'hFF, i == 3);
        wait_drained();

        // narrowing the width with the column already past it closes the row early
        program_regs(32'h0000_4241, 3'd2, 9'd8);
        send_cell("A", 1'b0);
        send_cell("B", 1'b0);
        send_cell("A", 1'b0);
        wait_drained();
        program_regs(cur_word, cur_len, 9'd2);
        send_cell("B", 1'b1);

        // random grids, mostly well formed with letters of the word, some noise
        while (cells_sent < RANDOM_CELLS) begin
            wait_drained();
            if ($urandom_range(0, 1) == 0) pick_config();
            idle_on = ($urandom_range(0, 3) != 0);
            noisy   = ($urandom_range(0, 9) == 0);
            run_grid();
        end
        wait_drained();

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("grid_word_search_counter: match");
        end else begin
            $display("grid_word_search_counter: mismatch");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("grid_word_search_counter: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
design/gwsc_pkg.sv
design/gwsc_cell.sv
design/gwsc_line_store.sv
design/grid_word_search_counter.sv
design/gwsc_checker.sv
tb/word_hit_checker.sv
tb/grid_word_search_counter_tb.sv
